// File: rtl/core/bcs_pkg.sv
// bcs_pkg: shared constants, codes and pipeline control types of the coverage sampler
// no dependencies; imported by every module of the block

package bcs_pkg;

	localparam int ADDR_W      = 11;
	localparam int GRID_DEPTH  = 2 ** ADDR_W;
	localparam int BYTE_W      = 8;
	localparam int FRAC_W      = 8;
	localparam int FRAC_ONE    = 2 ** FRAC_W;
	localparam int POS_X_W     = 7;
	localparam int POS_Y_W     = 6;
	localparam int OFFSET_W    = 20;
	localparam int OFF_INT_W   = OFFSET_W - FRAC_W;
	localparam int OFF_BIAS    = 2 ** (OFF_INT_W - 1);
	localparam int GAIN_W      = 12;
	localparam int CUT_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;
	localparam int NUM_STAGES  = 9;
	localparam int MEM_STAGE   = 6;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	typedef enum logic [0:0] {
		FUNC_WRITE  = 1'b0,
		FUNC_SAMPLE = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_X,
		REG_OFFSET_Y,
		REG_OPACITY_GAIN,
		REG_COVERAGE_CUT
	} cfg_reg_t;

	// load enables of the pipeline registers, one per stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
		logic s9;
	} pipe_en_t;

endpackage

// File: rtl/core/bcs_axis_map.sv
// bcs_axis_map: maps a screen coordinate to two wrapped grid cells and an 8-bit fraction
// three pipeline stages (s2..s4); uses bcs_pkg

module bcs_axis_map import bcs_pkg::*; #(
	parameter int SCREEN = 128,
	parameter int GRID   = 64,
	parameter int POS_W  = 7
) (
	input  logic                        clk,
	input  pipe_en_t                    en,
	input  logic [POS_W-1:0]            pos,
	input  logic signed [OFFSET_W-1:0]  offset,
	output logic [$clog2(GRID)-1:0]     cell0,
	output logic [$clog2(GRID)-1:0]     cell1,
	output logic [FRAC_W-1:0]           frac
);

	localparam int CW       = $clog2(GRID);
	localparam int TAB_N    = 2 ** POS_W;
	localparam int RECIP_SH = 24;
	localparam logic [RECIP_SH:0]    RECIP_M = (RECIP_SH + 1)'(((2 ** RECIP_SH) + GRID - 1) / GRID);
	localparam logic [OFF_INT_W-1:0] GRID_Q  = OFF_INT_W'(GRID);
	localparam logic [CW:0]          GRID_V  = (CW + 1)'(GRID);
	localparam logic [CW:0]          BIAS_K  = (CW + 1)'(OFF_BIAS % GRID);
	localparam logic [CW-1:0]        LAST    = CW'(GRID - 1);

	// constant mapping table: cell and fraction of pos * GRID / SCREEN in Q8
	logic [CW-1:0]     cell_tab [TAB_N];
	logic [FRAC_W-1:0] frac_tab [TAB_N];

	for (genvar i = 0; i < TAB_N; i++) begin : g_tab
		localparam int TV = (i * GRID * FRAC_ONE) / SCREEN;
		assign cell_tab[i] = CW'((TV / FRAC_ONE) % GRID);
		assign frac_tab[i] = FRAC_W'(TV % FRAC_ONE);
	end

	// stage 2: table lookup, fraction add, reciprocal multiply of the biased offset cell
	logic [FRAC_W:0]                   frac_sum;
	logic [OFF_INT_W-1:0]              off_u;
	logic [OFF_INT_W+RECIP_SH:0]       recip_prod;
	logic [CW-1:0]                     cell_s2;
	logic                              carry_s2;
	logic [FRAC_W-1:0]                 frac_s2;
	logic [OFF_INT_W-1:0]              offu_s2;
	logic [OFF_INT_W-1:0]              quo_s2;

	assign frac_sum   = {1'b0, frac_tab[pos]} + {1'b0, offset[FRAC_W-1:0]};
	assign off_u      = {~offset[OFFSET_W-1], offset[OFFSET_W-2:FRAC_W]};
	assign recip_prod = off_u * RECIP_M;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cell_s2  <= cell_tab[pos];
			carry_s2 <= frac_sum[FRAC_W];
			frac_s2  <= frac_sum[FRAC_W-1:0];
			offu_s2  <= off_u;
			quo_s2   <= recip_prod[RECIP_SH +: OFF_INT_W];
		end
	end

	// stage 3: remainder, then remove the bias to get the offset cell modulo GRID
	logic [OFF_INT_W-1:0] rem_full;
	logic [CW:0]          rem_ext;
	logic [CW:0]          off_mod;
	logic [CW-1:0]        cell_s3;
	logic                 carry_s3;
	logic [FRAC_W-1:0]    frac_s3;
	logic [CW-1:0]        offm_s3;

	assign rem_full = offu_s2 - quo_s2 * GRID_Q;
	assign rem_ext  = {1'b0, rem_full[CW-1:0]};
	assign off_mod  = (rem_ext >= BIAS_K) ? rem_ext - BIAS_K : rem_ext + (GRID_V - BIAS_K);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			cell_s3  <= cell_s2;
			carry_s3 <= carry_s2;
			frac_s3  <= frac_s2;
			offm_s3  <= off_mod[CW-1:0];
		end
	end

	// stage 4: wrapped sum and its right neighbour
	logic [CW:0]    cell_sum;
	logic [CW:0]    cell_wrap;
	logic [CW-1:0]  c0;
	logic [CW-1:0]  c0_s4;
	logic [CW-1:0]  c1_s4;
	logic [FRAC_W-1:0] frac_s4;

	assign cell_sum  = {1'b0, cell_s3} + {1'b0, offm_s3} + (CW + 1)'(carry_s3);
	assign cell_wrap = (cell_sum >= GRID_V) ? cell_sum - GRID_V : cell_sum;
	assign c0        = cell_wrap[CW-1:0];

	always_ff @(posedge clk) begin
		if (en.s4) begin
			c0_s4   <= c0;
			c1_s4   <= (c0 == LAST) ? '0 : c0 + 1'b1;
			frac_s4 <= frac_s3;
		end
	end

	assign cell0 = c0_s4;
	assign cell1 = c1_s4;
	assign frac  = frac_s4;

endmodule

// File: rtl/core/bcs_grid_mem.sv
// bcs_grid_mem: density grid store, two copies with two read ports each
// one write and four registered reads per cycle, as wr_en and rd_en allow; uses bcs_pkg

module bcs_grid_mem import bcs_pkg::*; (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [BYTE_W-1:0]           wr_data,
	input  logic                        rd_en,
	input  logic [3:0][ADDR_W-1:0]      rd_addr,
	output logic [3:0][BYTE_W-1:0]      rd_data
);

	logic [BYTE_W-1:0] mem_top [GRID_DEPTH];
	logic [BYTE_W-1:0] mem_bot [GRID_DEPTH];
	logic [3:0][BYTE_W-1:0] rd_data_s6;

	// upper row pair from one copy, lower row pair from the other
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_top[wr_addr] <= wr_data;
			mem_bot[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s6[0] <= mem_top[rd_addr[0]];
			rd_data_s6[1] <= mem_top[rd_addr[1]];
			rd_data_s6[2] <= mem_bot[rd_addr[2]];
			rd_data_s6[3] <= mem_bot[rd_addr[3]];
		end
	end

	assign rd_data = rd_data_s6;

endmodule

// File: rtl/core/bcs_blend.sv
// bcs_blend: bilinear blend of four neighbours, opacity gain and coverage cut
// three pipeline stages (s7..s9); uses bcs_pkg

module bcs_blend import bcs_pkg::*; (
	input  logic                   clk,
	input  pipe_en_t               en,
	input  logic [3:0][BYTE_W-1:0] texel,
	input  logic [FRAC_W-1:0]      tx,
	input  logic [FRAC_W-1:0]      ty,
	input  logic [GAIN_W-1:0]      gain,
	input  logic [CUT_W-1:0]       cut,
	output logic [BYTE_W-1:0]      coverage
);

	localparam int ROW_W = BYTE_W + FRAC_W;
	localparam int VAL_W = BYTE_W + 2 * FRAC_W;
	localparam logic [VAL_W-1:0] ROUND_HALF = VAL_W'(1) << (2 * FRAC_W - 1);

	// a*256 + (b-a)*t, always within 0..255*256
	function automatic logic [ROW_W-1:0] lerp_row(input logic [BYTE_W-1:0] a,
			input logic [BYTE_W-1:0] b, input logic [FRAC_W-1:0] t);
		logic signed [BYTE_W:0]         diff;
		logic signed [BYTE_W+FRAC_W+1:0] prod;
		logic signed [BYTE_W+FRAC_W+1:0] sum;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = diff * $signed({1'b0, t});
		sum  = $signed({2'b00, a, {FRAC_W{1'b0}}}) + prod;
		return sum[ROW_W-1:0];
	endfunction

	// stage 7: horizontal blends
	logic [ROW_W-1:0]  top_s7;
	logic [ROW_W-1:0]  bot_s7;
	logic [FRAC_W-1:0] ty_s7;

	always_ff @(posedge clk) begin
		if (en.s7) begin
			top_s7 <= lerp_row(texel[0], texel[1], tx);
			bot_s7 <= lerp_row(texel[2], texel[3], tx);
			ty_s7  <= ty;
		end
	end

	// stage 8: vertical blend and round half up
	logic signed [ROW_W:0]            vdiff;
	logic signed [ROW_W+FRAC_W+1:0]   vprod;
	logic signed [ROW_W+FRAC_W+1:0]   vsum;
	logic [VAL_W-1:0]                 vround;
	logic [BYTE_W-1:0]                byte_s8;

	assign vdiff  = $signed({1'b0, bot_s7}) - $signed({1'b0, top_s7});
	assign vprod  = vdiff * $signed({1'b0, ty_s7});
	assign vsum   = $signed({2'b00, top_s7, {FRAC_W{1'b0}}}) + vprod;
	assign vround = vsum[VAL_W-1:0] + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en.s8) begin
			byte_s8 <= vround[VAL_W-1 -: BYTE_W];
		end
	end

	// stage 9: gain with saturation, then floor-at-zero cut
	logic [BYTE_W+GAIN_W-1:0] gprod;
	logic [GAIN_W-1:0]        gshift;
	logic [BYTE_W-1:0]        scaled;
	logic [BYTE_W-1:0]        coverage_s9;

	assign gprod  = byte_s8 * gain;
	assign gshift = gprod[BYTE_W+GAIN_W-1:FRAC_W];
	assign scaled = (|gshift[GAIN_W-1:BYTE_W]) ? '1 : gshift[BYTE_W-1:0];

	always_ff @(posedge clk) begin
		if (en.s9) begin
			coverage_s9 <= (scaled > cut) ? scaled - cut : '0;
		end
	end

	assign coverage = coverage_s9;

endmodule

// File: rtl/core/wrapped_bilinear_coverage_sampler.sv
// Wrapped bilinear coverage sampler, top level.
// Item channel (item_valid / item_stall): func selects a grid write (entry_index,
// entry_value) or a coverage sample of screen cell (pos_x, pos_y). Result channel
// (result_valid / result_stall) returns one coverage byte per sample, in order;
// writes return nothing. Configuration is a plain write port (cfg_write, cfg_index,
// cfg_data) for offset_x, offset_y, opacity_gain and coverage_cut; write it only
// while no sample is in flight.
// Throughput: one item per cycle while item_stall is low. A nine-stage pipeline: capture
// (s1), coordinate mapping and wrap (s2..s4), address generation (s5), grid read or
// write (s6), blend and gain (s7..s9). A sample's result is shown from s9. Grid writes
// take effect in s6, in item order.
// Result stall: stages fill from the output back; item_stall rises only when all
// nine stages hold an item and the result is stalled. Nothing is lost or repeated.
// Reset clears the valid bits and the configuration registers (opacity_gain to 256).
// The 2048-entry grid is not cleared: entries must be written before they are read.
// Dependencies: bcs_pkg, bcs_axis_map, bcs_grid_mem, bcs_blend.

module wrapped_bilinear_coverage_sampler import bcs_pkg::*; #(
	parameter int SCREEN_W = 128,
	parameter int SCREEN_H = 64,
	parameter int GRID_W   = 64,
	parameter int GRID_H   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  func,
	input  logic [POS_X_W-1:0]    pos_x,
	input  logic [POS_Y_W-1:0]    pos_y,
	input  logic [ADDR_W-1:0]     entry_index,
	input  logic [BYTE_W-1:0]     entry_value,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [BYTE_W-1:0]     coverage
);

	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(GRID_W);

	// configuration registers
	logic signed [OFFSET_W-1:0] offset_x_q;
	logic signed [OFFSET_W-1:0] offset_y_q;
	logic [GAIN_W-1:0]          gain_q;
	logic [CUT_W-1:0]           cut_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			gain_q     <= GAIN_RESET;
			cut_q      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OFFSET_X:     offset_x_q <= cfg_data[OFFSET_W-1:0];
				REG_OFFSET_Y:     offset_y_q <= cfg_data[OFFSET_W-1:0];
				REG_OPACITY_GAIN: gain_q     <= cfg_data[GAIN_W-1:0];
				REG_COVERAGE_CUT: cut_q      <= cfg_data[CUT_W-1:0];
			endcase
		end
	end

	// pipeline control: a stage loads when it is empty or the stage after it moves
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES:1]   vld_next;
	logic [NUM_STAGES+1:1] ready;
	pipe_en_t              pipe_en;
	func_t                 func_s1, func_s2, func_s3, func_s4, func_s5;

	assign ready[NUM_STAGES+1] = !result_stall;
	for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_ready
		assign ready[k] = !vld_q[k] || ready[k+1];
	end

	assign pipe_en = '{s1: ready[1], s2: ready[2], s3: ready[3], s4: ready[4], s5: ready[5],
		s6: ready[6], s7: ready[7], s8: ready[8], s9: ready[9]};

	always_comb begin
		vld_next[1] = item_valid;
		for (int k = 2; k <= NUM_STAGES; k++) begin
			vld_next[k] = vld_q[k-1];
		end
		// writes end at the grid stage
		vld_next[MEM_STAGE] = vld_q[MEM_STAGE-1] && (func_s5 == FUNC_SAMPLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (ready[k]) begin
					vld_q[k] <= vld_next[k];
				end
			end
		end
	end

	assign item_stall   = !ready[1];
	assign result_valid = vld_q[NUM_STAGES];

	// stage 1: capture the transaction
	logic [POS_X_W-1:0] pos_x_s1;
	logic [POS_Y_W-1:0] pos_y_s1;
	logic [ADDR_W-1:0]  idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [BYTE_W-1:0]  val_s1, val_s2, val_s3, val_s4, val_s5;

	always_ff @(posedge clk) begin
		if (pipe_en.s1) begin
			func_s1  <= func_t'(func);
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			idx_s1   <= entry_index;
			val_s1   <= entry_value;
		end
	end

	// write payload follows the sample path down to the grid stage
	always_ff @(posedge clk) begin
		if (pipe_en.s2) begin
			func_s2 <= func_s1;
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
		end
		if (pipe_en.s3) begin
			func_s3 <= func_s2;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
		end
		if (pipe_en.s4) begin
			func_s4 <= func_s3;
			idx_s4  <= idx_s3;
			val_s4  <= val_s3;
		end
		if (pipe_en.s5) begin
			func_s5 <= func_s4;
			idx_s5  <= idx_s4;
			val_s5  <= val_s4;
		end
	end

	// stages 2..4: coordinate mapping per axis
	logic [XW-1:0]     x0_s4, x1_s4;
	logic [YW-1:0]     y0_s4, y1_s4;
	logic [FRAC_W-1:0] tx_s4, ty_s4;

	bcs_axis_map #(
		.SCREEN (SCREEN_W),
		.GRID   (GRID_W),
		.POS_W  (POS_X_W)
	) u_axis_x (
		.clk    (clk),
		.en     (pipe_en),
		.pos    (pos_x_s1),
		.offset (offset_x_q),
		.cell0  (x0_s4),
		.cell1  (x1_s4),
		.frac   (tx_s4)
	);

	bcs_axis_map #(
		.SCREEN (SCREEN_H),
		.GRID   (GRID_H),
		.POS_W  (POS_Y_W)
	) u_axis_y (
		.clk    (clk),
		.en     (pipe_en),
		.pos    (pos_y_s1),
		.offset (offset_y_q),
		.cell0  (y0_s4),
		.cell1  (y1_s4),
		.frac   (ty_s4)
	);

	// stage 5: grid addresses, taken modulo the store depth
	logic [ADDR_W-1:0]        row0, row1;
	logic [3:0][ADDR_W-1:0]   addr_s5;
	logic [FRAC_W-1:0]        tx_s5, ty_s5, tx_s6, ty_s6;

	assign row0 = ADDR_W'(y0_s4) * ROW_STRIDE;
	assign row1 = ADDR_W'(y1_s4) * ROW_STRIDE;

	always_ff @(posedge clk) begin
		if (pipe_en.s5) begin
			addr_s5[0] <= row0 + ADDR_W'(x0_s4);
			addr_s5[1] <= row0 + ADDR_W'(x1_s4);
			addr_s5[2] <= row1 + ADDR_W'(x0_s4);
			addr_s5[3] <= row1 + ADDR_W'(x1_s4);
			tx_s5      <= tx_s4;
			ty_s5      <= ty_s4;
		end
		if (pipe_en.s6) begin
			tx_s6 <= tx_s5;
			ty_s6 <= ty_s5;
		end
	end

	// stage 6: grid access
	logic [3:0][BYTE_W-1:0] texel_s6;
	logic                   grid_wr;

	assign grid_wr = pipe_en.s6 && vld_q[MEM_STAGE-1] && (func_s5 == FUNC_WRITE);

	bcs_grid_mem u_grid (
		.clk     (clk),
		.wr_en   (grid_wr),
		.wr_addr (idx_s5),
		.wr_data (val_s5),
		.rd_en   (pipe_en.s6),
		.rd_addr (addr_s5),
		.rd_data (texel_s6)
	);

	// stages 7..9: blend, gain and cut
	bcs_blend u_blend (
		.clk      (clk),
		.en       (pipe_en),
		.texel    (texel_s6),
		.tx       (tx_s6),
		.ty       (ty_s6),
		.gain     (gain_q),
		.cut      (cut_q),
		.coverage (coverage)
	);

endmodule

// File: rtl/core/bcs_checker.sv
// bcs_checker: port-level assertions for the coverage sampler, bound to the top level
// uses bcs_pkg; watches the item and result channels only

module bcs_checker import bcs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input logic                  func,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [BYTE_W-1:0]     coverage
);

	localparam int CNT_W = $clog2(NUM_STAGES + 1);

	logic             sample_acc;
	logic             result_acc;
	logic [CNT_W-1:0] pending_q;

	assign sample_acc = item_valid && !item_stall && (func == FUNC_SAMPLE);
	assign result_acc = result_valid && !result_stall;

	// samples taken whose coverage has not been delivered yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + CNT_W'(sample_acc) - CNT_W'(result_acc);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(coverage))
		else $error("stalled result changed or dropped");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stall without a stalled result");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != '0)
		else $error("result transaction without a pending sample");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc && (pending_q == '0) |-> ##NUM_STAGES result_valid)
		else $error("sample through an empty pipeline missed its latency");

endmodule

bind wrapped_bilinear_coverage_sampler bcs_checker u_bcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.func         (func),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.coverage     (coverage)
);

// File: bench/coverage_checker.sv
`timescale 1ns / 100ps
// coverage_checker: watches the item, result and register ports of the coverage sampler,
// predicts each sample's coverage byte and compares results in order
// depends on bcs_pkg for widths, function codes and register indexes

module coverage_checker import bcs_pkg::*; #(
	parameter int SCREEN_W = 128,
	parameter int SCREEN_H = 64,
	parameter int GRID_W   = 64,
	parameter int GRID_H   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  logic                  func,
	input  logic [POS_X_W-1:0]    pos_x,
	input  logic [POS_Y_W-1:0]    pos_y,
	input  logic [ADDR_W-1:0]     entry_index,
	input  logic [BYTE_W-1:0]     entry_value,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  logic [BYTE_W-1:0]     coverage,
	output int                    failures,
	output int                    pending,
	output int                    checked
);

	localparam int BYTE_MAX   = 2 ** BYTE_W - 1;
	localparam int ROUND_HALF = 2 ** (2 * FRAC_W - 1);

	logic [BYTE_W-1:0] grid_copy [GRID_DEPTH];
	int                shift_x;
	int                shift_y;
	logic [GAIN_W-1:0] gain;
	logic [CUT_W-1:0]  cut;
	logic [BYTE_W-1:0] coverage_due [$];
	logic [BYTE_W-1:0] due;

	task automatic report_mismatch(input string what);
		$display("checker: %s at %0t ns", what, $realtime);
		failures++;
	endtask

	// q8 coordinate to wrapped cell and fraction; arithmetic shift floors negatives
	function automatic void map_axis(input int q8, input int cells, output int grid_cell,
			output int frac);
		frac = q8 & (FRAC_ONE - 1);
		grid_cell = (q8 >>> FRAC_W) % cells;
		if (grid_cell < 0)
			grid_cell += cells;
	endfunction

	function automatic int density_at(input int row, input int col);
		return int'(grid_copy[(row * GRID_W + col) % GRID_DEPTH]);
	endfunction

	function automatic logic [BYTE_W-1:0] predict_coverage(input logic [POS_X_W-1:0] px,
			input logic [POS_Y_W-1:0] py);
		int fx, fy, x0, x1, y0, y1, tx, ty;
		int a, b, d, e, top, bottom, blend, dens, scaled;
		fx = int'(px) * GRID_W * FRAC_ONE / SCREEN_W + shift_x;
		fy = int'(py) * GRID_H * FRAC_ONE / SCREEN_H + shift_y;
		map_axis(fx, GRID_W, x0, tx);
		map_axis(fy, GRID_H, y0, ty);
		x1 = (x0 + 1) % GRID_W;
		y1 = (y0 + 1) % GRID_H;
		a = density_at(y0, x0);
		b = density_at(y0, x1);
		d = density_at(y1, x0);
		e = density_at(y1, x1);
		top = a * FRAC_ONE + (b - a) * tx;
		bottom = d * FRAC_ONE + (e - d) * tx;
		blend = top * FRAC_ONE + (bottom - top) * ty;
		if (blend < 0)
			blend = 0;
		dens = (blend + ROUND_HALF) >>> (2 * FRAC_W);
		if (dens > BYTE_MAX)
			dens = BYTE_MAX;
		scaled = (dens * int'(gain)) >>> FRAC_W;
		if (scaled > BYTE_MAX)
			scaled = BYTE_MAX;
		return (scaled > int'(cut)) ? BYTE_W'(scaled - int'(cut)) : '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x = 0;
			shift_y = 0;
			gain = GAIN_RESET;
			cut = '0;
			coverage_due.delete();
			failures = 0;
			pending = 0;
			checked = 0;
		end else begin
			// results leave before the same edge's transaction can add an expectation
			if (result_valid && !result_stall) begin
				if (coverage_due.size() == 0) begin
					report_mismatch($sformatf("coverage %0d with no sample waiting",
						coverage));
				end else begin
					due = coverage_due.pop_front();
					checked++;
					if (coverage !== due)
						report_mismatch($sformatf("coverage %0d, predicted %0d",
							coverage, due));
				end
			end
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_OFFSET_X:     shift_x = int'(signed'(cfg_data));
					REG_OFFSET_Y:     shift_y = int'(signed'(cfg_data));
					REG_OPACITY_GAIN: gain = cfg_data[GAIN_W-1:0];
					REG_COVERAGE_CUT: cut = cfg_data[CUT_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				if (func_t'(func) == FUNC_WRITE)
					grid_copy[entry_index] = entry_value;
				else
					coverage_due.push_back(predict_coverage(pos_x, pos_y));
			end
			pending = coverage_due.size();
		end
	end

endmodule

// File: bench/wrapped_bilinear_coverage_sampler_tb.sv
`timescale 1ns / 100ps
// wrapped_bilinear_coverage_sampler_tb: clock, reset, stimulus and verdict for the sampler
// depends on bcs_pkg, the sampler RTL and coverage_checker

module wrapped_bilinear_coverage_sampler_tb;
	import bcs_pkg::*;

	localparam int SCREEN_W     = 128;
	localparam int SCREEN_H     = 64;
	localparam int GRID_W       = 64;
	localparam int GRID_H       = 32;
	localparam int DRAIN_CYCLES = 2 * NUM_STAGES;
	localparam int CYCLE_LIMIT  = 40000;
	localparam int OFFSET_MIN   = -(2 ** (OFFSET_W - 1));
	localparam int OFFSET_MAX   = 2 ** (OFFSET_W - 1) - 1;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  func = 1'b0;
	logic [POS_X_W-1:0]    pos_x = '0;
	logic [POS_Y_W-1:0]    pos_y = '0;
	logic [ADDR_W-1:0]     entry_index = '0;
	logic [BYTE_W-1:0]     entry_value = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [BYTE_W-1:0]     coverage;

	int failures, pending, checked;
	int gap_pct = 0;
	int stall_pct = 0;
	int cur_ox = 0;
	int cur_oy = 0;
	int writes_sent = 0;
	int items_sent = 0;
	int settings_applied = 0;
	int cycles = 0;
	bit filled [GRID_DEPTH];

	wrapped_bilinear_coverage_sampler #(
		.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H), .GRID_W(GRID_W), .GRID_H(GRID_H)
	) dut (.*);

	coverage_checker #(
		.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H), .GRID_W(GRID_W), .GRID_H(GRID_H)
	) cov_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples still waiting", cycles, pending);
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input func_t kind, input int px, input int py, input int idx,
			input int val);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		func <= kind;
		pos_x <= POS_X_W'(px);
		pos_y <= POS_Y_W'(py);
		entry_index <= ADDR_W'(idx);
		entry_value <= BYTE_W'(val);
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_entry(input int idx, input int val);
		send_item(FUNC_WRITE, $urandom_range(SCREEN_W - 1), $urandom_range(SCREEN_H - 1),
			idx, val);
		filled[idx] = 1'b1;
		writes_sent++;
	endtask

	// grid entry that a sample of (px, py) reads as one of its four neighbours
	function automatic int entry_near(input int px, input int py, input int dx, input int dy);
		int col, row;
		col = ((px * GRID_W * FRAC_ONE / SCREEN_W + cur_ox) >>> FRAC_W) + dx;
		row = ((py * GRID_H * FRAC_ONE / SCREEN_H + cur_oy) >>> FRAC_W) + dy;
		col = col % GRID_W;
		if (col < 0)
			col += GRID_W;
		row = row % GRID_H;
		if (row < 0)
			row += GRID_H;
		return (row * GRID_W + col) % GRID_DEPTH;
	endfunction

	// the grid is undefined after reset, so neighbours are written before their first read
	task automatic sample_cell(input int px, input int py);
		int ent;
		for (int k = 0; k < 4; k++) begin
			ent = entry_near(px, py, k % 2, k / 2);
			if (!filled[ent])
				write_entry(ent, pick_density());
		end
		send_item(FUNC_SAMPLE, px, py, $urandom_range(GRID_DEPTH - 1),
			$urandom_range(2 ** BYTE_W - 1));
	endtask

	task automatic put_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= which;
		cfg_data <= data;
		@(negedge clk);
	endtask

	// only called with nothing in flight; unused upper data bits are randomized
	task automatic apply_settings(input int ox, input int oy, input int gain, input int cut);
		put_reg(REG_OFFSET_X, CFG_DATA_W'(ox));
		put_reg(REG_OFFSET_Y, CFG_DATA_W'(oy));
		put_reg(REG_OPACITY_GAIN,
			CFG_DATA_W'(($urandom_range(255) << GAIN_W) | gain));
		put_reg(REG_COVERAGE_CUT,
			CFG_DATA_W'(($urandom_range(4095) << CUT_W) | cut));
		cfg_write <= 1'b0;
		cur_ox = ox;
		cur_oy = oy;
		settings_applied++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int pick_density();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 2 ** BYTE_W - 1;
		return $urandom_range(2 ** BYTE_W - 1);
	endfunction

	// mostly samples, with writes landing right before reads of the same neighbours
	task automatic run_random(input int count);
		int stop, r, px, py;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			px = $urandom_range(SCREEN_W - 1);
			py = $urandom_range(SCREEN_H - 1);
			if (r < 30) begin
				write_entry($urandom_range(GRID_DEPTH - 1), pick_density());
			end else if (r < 50) begin
				write_entry(entry_near(px, py, $urandom_range(1), $urandom_range(1)),
					pick_density());
				sample_cell(px, py);
			end else if (r < 55) begin
				sample_cell(px, py);
				write_entry(entry_near(px, py, $urandom_range(1), $urandom_range(1)),
					pick_density());
				sample_cell(px, py);
			end else begin
				sample_cell(px, py);
			end
		end
	endtask

	initial begin
		int ox, oy, gain, cut;
		gap_pct = 25;
		stall_pct = 60;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// full density at the origin, then the far corner that wraps to the origin
		write_entry(0, 255);
		write_entry(1, 255);
		write_entry(GRID_W, 255);
		write_entry(GRID_W + 1, 255);
		sample_cell(0, 0);
		sample_cell(SCREEN_W - 1, SCREEN_H - 1);
		// half a step between 0 and 1 rounds up
		write_entry(0, 0);
		write_entry(1, 1);
		write_entry(GRID_W, 0);
		write_entry(GRID_W + 1, 1);
		sample_cell(1, 0);
		write_entry(GRID_DEPTH - 1, 255);
		write_entry(GRID_DEPTH - 2, 0);
		sample_cell(SCREEN_W - 1, SCREEN_H - 1);
		// read right behind a write to the same entry
		write_entry(0, 200);
		sample_cell(0, 0);
		sample_cell(0, 0);

		for (int p = 0; p < 7; p++) begin
			settle();
			case (p)
				0: begin ox = OFFSET_MIN; oy = OFFSET_MAX; gain = 4095; cut = 0; end
				1: begin ox = OFFSET_MAX; oy = OFFSET_MIN; gain = 0; cut = 255; end
				2: begin ox = 0; oy = 0; gain = 256; cut = 255; end
				default: begin
					ox = int'($urandom_range(2 ** OFFSET_W - 1)) + OFFSET_MIN;
					oy = int'($urandom_range(2 ** OFFSET_W - 1)) + OFFSET_MIN;
					gain = $urandom_range(4095);
					cut = $urandom_range(63);
				end
			endcase
			if (p >= 5) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (p >= 3) begin
				gap_pct = 60;
				stall_pct = 25;
			end
			apply_settings(ox, oy, gain, cut);
			sample_cell(0, 0);
			sample_cell(SCREEN_W - 1, SCREEN_H - 1);
			run_random((p < 3) ? 70 : 140);
		end

		item_valid <= 1'b0;
		settle();
		$display("run: %0d grid writes and %0d checked samples over %0d register settings",
			writes_sent, checked, settings_applied);
		$display("run: offsets and gain at both extremes, wrap at every edge, stalls on both sides");
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/bcs_pkg.sv
rtl/core/bcs_axis_map.sv
rtl/core/bcs_grid_mem.sv
rtl/core/bcs_blend.sv
rtl/core/wrapped_bilinear_coverage_sampler.sv
rtl/core/bcs_checker.sv
bench/coverage_checker.sv
bench/wrapped_bilinear_coverage_sampler_tb.sv
